@@ design/mmdf_pkg.sv @@
// ----------------------------------------------------------------------------
// mmdf_pkg: shared types and constants for the memory map / display fetch
// Operation codes, configuration indexes, address map constants and the
// window remap of the alternate machine.
// ----------------------------------------------------------------------------
package mmdf_pkg;

    localparam int unsigned STORE_BYTES = 65536;

    localparam int unsigned ADDR_BITS  = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FETCH = 2'd2,
        OP_LOAD  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PAT,
        ST_HOLD
    } t_state;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRUE_HIRES = 3'd6;

    localparam logic [1:0] MODE_ALT = 2'd2;

    localparam logic [ADDR_BITS-1:0] ALT_WR_FLOOR = 16'h2000;
    localparam logic [ADDR_BITS-1:0] ALT_BLANK_LO = 16'h2800;
    localparam logic [ADDR_BITS-1:0] ALT_BLANK_HI = 16'h2fff;
    localparam logic [7:0]           HIRES_I_MIN  = 8'd32;

    typedef struct packed {
        logic [1:0]           mode;
        logic                 protect_rom;
        logic [ADDR_BITS-1:0] rom_top;
        logic [ADDR_BITS-1:0] ram_top;
        logic                 mirror_upper_ram;
        logic                 fast_mode;
        logic                 true_hires;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        mode:             2'd1,
        protect_rom:      1'b1,
        rom_top:          16'd8191,
        ram_top:          16'd32767,
        mirror_upper_ram: 1'b0,
        fast_mode:        1'b0,
        true_hires:       1'b0
    };

    // one decoded store access
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic                 we;
        logic                 force_ff;
        logic                 display;
    } t_access;

    // five 1K windows moved up in the alternate machine (windows are disjoint)
    function automatic logic [ADDR_BITS-1:0] remap_alt(input logic [ADDR_BITS-1:0] a);
        logic [ADDR_BITS-1:0] ofs;
        ofs = '0;
        if (a >= 16'h2000 && a <= 16'h23ff) ofs = 16'h0400;
        if (a >= 16'h2800 && a <= 16'h2bff) ofs = 16'h0400;
        if (a >= 16'h3000 && a <= 16'h33ff) ofs = 16'h0c00;
        if (a >= 16'h3400 && a <= 16'h37ff) ofs = 16'h0800;
        if (a >= 16'h3800 && a <= 16'h3bff) ofs = 16'h0400;
        return a + ofs;
    endfunction

endpackage

@@ design/mmdf_ram.sv @@
// ----------------------------------------------------------------------------
// mmdf_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module mmdf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/mmdf_decode.sv @@
// ----------------------------------------------------------------------------
// mmdf_decode: access decoder
// Maps one request to a store address, write enable, forced 0xff read and
// display-fetch flag under the current machine configuration.
// ----------------------------------------------------------------------------
module mmdf_decode (
    input  mmdf_pkg::t_cfg                     i_cfg,
    input  mmdf_pkg::t_op                      i_op,
    input  logic [mmdf_pkg::ADDR_BITS-1:0]     i_addr,
    output mmdf_pkg::t_access                  o_acc
);

    logic [mmdf_pkg::ADDR_BITS-1:0] remapped;
    logic [mmdf_pkg::ADDR_BITS-1:0] low_half;
    logic                           alt;

    always_comb begin
        remapped = mmdf_pkg::remap_alt(i_addr);
        low_half = {1'b0, i_addr[mmdf_pkg::ADDR_BITS-2:0]};
        alt      = (i_cfg.mode == mmdf_pkg::MODE_ALT);
        o_acc    = '0;
        o_acc.addr = i_addr;
        case (i_op)
            mmdf_pkg::OP_READ: begin
                if (alt) begin
                    o_acc.addr     = remapped;
                    o_acc.force_ff = (remapped >= mmdf_pkg::ALT_BLANK_LO) &&
                                     (remapped <= mmdf_pkg::ALT_BLANK_HI);
                end else if (i_addr[mmdf_pkg::ADDR_BITS-1] && i_cfg.mirror_upper_ram) begin
                    o_acc.addr = low_half;
                end else begin
                    o_acc.force_ff = (i_addr > i_cfg.ram_top);
                end
            end
            mmdf_pkg::OP_WRITE: begin
                if (alt) begin
                    o_acc.addr = remapped;
                    o_acc.we   = (i_addr >= mmdf_pkg::ALT_WR_FLOOR);
                end else begin
                    o_acc.we = !(i_cfg.protect_rom && (i_addr <= i_cfg.rom_top));
                end
            end
            mmdf_pkg::OP_LOAD: begin
                o_acc.we = 1'b1;
            end
            mmdf_pkg::OP_FETCH: begin
                // alternate machine fetches the raw address, no display trick
                if (!alt) begin
                    o_acc.addr     = low_half;
                    o_acc.force_ff = (low_half > i_cfg.ram_top);
                    o_acc.display  = i_addr[mmdf_pkg::ADDR_BITS-1];
                end
            end
            default: begin
                o_acc = '0;
            end
        endcase
    end

endmodule

@@ design/memory_map_display_fetch.sv @@
// ----------------------------------------------------------------------------
// memory_map_display_fetch: 64K memory map with display pattern fetch
// Single-port store with a request sequencer, address decoder and output
// register.
//
//   channel  | dir | handshake                  | payload
//   ---------+-----+----------------------------+---------------------------
//   s_axis   | in  | s_axis_tvalid/tready       | tdata: access fields,
//            |     |                            | tuser: operation
//   m_axis   | out | m_axis_tvalid/tready       | tdata: read_data, shift_value
//            |     |                            | tuser: shift_load
//   cfg      | in  | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// Writes and raw loads finish as taken; reads and plain fetches need a store
// read, display fetches a store read and then a pattern read (skipped in fast
// mode): every access goes through the one port of the store, and a display
// fetch needs the fetched byte before its pattern read. After reset the store
// is cleared, one byte a cycle, over all STORE_BYTES (65536) addresses; no
// request is taken then, configuration writes are. A result waiting in the
// output register stalls the sequencer only when the next result is ready.
// ----------------------------------------------------------------------------
module memory_map_display_fetch #(
    parameter int unsigned STORE_BYTES = mmdf_pkg::STORE_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // address[15:0], write_data[23:16], i_register[31:24], r_low[38:32],
    // r_bit_seven[39], row_count[42:40], zero[47:43]
    input  logic [47:0]                     s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_data[7:0], shift_value[15:8]
    output logic [15:0]                     m_axis_tdata,
    // shift_load[0]
    output logic [0:0]                      m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [mmdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mmdf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned ADDR_W = $clog2(STORE_BYTES);

    mmdf_pkg::t_state  r_state, n_state;
    mmdf_pkg::t_cfg    r_cfg;
    mmdf_pkg::t_access acc;
    mmdf_pkg::t_op     in_op;

    logic [ADDR_W-1:0] r_clr_addr;

    // request fields kept for the pattern read
    logic       r_force, r_display, r_inv;
    logic [7:0] r_i;
    logic [6:0] r_rlo;
    logic       r_r7;
    logic [2:0] r_row;

    // pending result while output is busy
    logic [7:0] r_res_rd, r_res_sv;
    logic       r_res_load;

    logic       r_out_valid;
    logic [7:0] r_out_rd, r_out_sv;
    logic       r_out_load;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_q;

    logic       accept, out_free, fin;
    logic [7:0] fin_rd, fin_sv, rd_byte;
    logic       fin_load;
    logic [mmdf_pkg::ADDR_BITS-1:0] pat_addr;

    assign in_op    = mmdf_pkg::t_op'(s_axis_tuser);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    mmdf_decode u_decode (
        .i_cfg  (r_cfg),
        .i_op   (in_op),
        .i_addr (s_axis_tdata[15:0]),
        .o_acc  (acc)
    );

    mmdf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    always_comb begin
        rd_byte = r_force ? 8'hff : ram_q;
        if (r_cfg.true_hires && (r_i >= mmdf_pkg::HIRES_I_MIN)) begin
            pat_addr = {r_i, r_r7, r_rlo - 7'd1};
        end else begin
            // character bit 5 lands on bit 8 together with I bit 0
            pat_addr = {r_i, 8'h00} | {7'b0, rd_byte[5:0], r_row};
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = acc.addr[ADDR_W-1:0];
        ram_wdata     = s_axis_tdata[23:16];
        fin           = 1'b0;
        fin_rd        = '0;
        fin_sv        = '0;
        fin_load      = 1'b0;
        case (r_state)
            mmdf_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = '0;
                if (&r_clr_addr) begin
                    n_state = mmdf_pkg::ST_IDLE;
                end
            end
            mmdf_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (in_op inside {mmdf_pkg::OP_WRITE, mmdf_pkg::OP_LOAD}) begin
                        ram_we = acc.we;
                        fin    = 1'b1;
                    end else begin
                        n_state = mmdf_pkg::ST_READ;
                    end
                end
            end
            mmdf_pkg::ST_READ: begin
                if (r_display && !rd_byte[6]) begin
                    if (r_cfg.fast_mode) begin
                        fin = 1'b1;
                    end else begin
                        ram_addr = pat_addr[ADDR_W-1:0];
                        n_state  = mmdf_pkg::ST_PAT;
                    end
                end else begin
                    fin    = 1'b1;
                    fin_rd = rd_byte;
                end
            end
            mmdf_pkg::ST_PAT: begin
                fin      = 1'b1;
                fin_load = 1'b1;
                fin_sv   = r_inv ? ~ram_q : ram_q;
            end
            mmdf_pkg::ST_HOLD: begin
                fin      = 1'b1;
                fin_rd   = r_res_rd;
                fin_sv   = r_res_sv;
                fin_load = r_res_load;
            end
            default: begin
                n_state = mmdf_pkg::ST_IDLE;
            end
        endcase
        if (fin) begin
            n_state = out_free ? mmdf_pkg::ST_IDLE : mmdf_pkg::ST_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mmdf_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == mmdf_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= mmdf_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mmdf_pkg::CFG_MODE:       r_cfg.mode             <= i_cfg_data[1:0];
                mmdf_pkg::CFG_PROTECT:    r_cfg.protect_rom      <= i_cfg_data[0];
                mmdf_pkg::CFG_ROM_TOP:    r_cfg.rom_top          <= i_cfg_data;
                mmdf_pkg::CFG_RAM_TOP:    r_cfg.ram_top          <= i_cfg_data;
                mmdf_pkg::CFG_MIRROR:     r_cfg.mirror_upper_ram <= i_cfg_data[0];
                mmdf_pkg::CFG_FAST:       r_cfg.fast_mode        <= i_cfg_data[0];
                mmdf_pkg::CFG_TRUE_HIRES: r_cfg.true_hires       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_force   <= acc.force_ff;
            r_display <= acc.display;
            r_i       <= s_axis_tdata[31:24];
            r_rlo     <= s_axis_tdata[38:32];
            r_r7      <= s_axis_tdata[39];
            r_row     <= s_axis_tdata[42:40];
        end
        if (r_state == mmdf_pkg::ST_READ) begin
            r_inv <= rd_byte[7];
        end
        if (fin && !out_free) begin
            r_res_rd   <= fin_rd;
            r_res_sv   <= fin_sv;
            r_res_load <= fin_load;
        end
        if (fin && out_free) begin
            r_out_rd   <= fin_rd;
            r_out_sv   <= fin_sv;
            r_out_load <= fin_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_sv, r_out_rd};
    assign m_axis_tuser  = r_out_load;

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for memory_map_display_fetch
// Directed table (reset map, protection, display pattern loads, hires, fast
// mode, alternate windows, mirror) followed by random phases under several
// map settings. Every response is checked against its typed table answer or a
// local model of the store and the address map; random idle on both sides,
// one long output stall and one full drain.
// ----------------------------------------------------------------------------
module tb;

    localparam int  SETTLE_CYCLES  = 8;
    localparam int  PHASE_ITEMS    = 150;
    localparam int  PHASES         = 8;
    localparam int  RX_HOLD_CYCLES = 400;
    localparam int  MAX_GAP        = 6;
    localparam logic PRED  = 1'b0;
    localparam logic TYPED = 1'b1;

    // short names for the directed table
    localparam mmdf_pkg::t_op DO_READ  = mmdf_pkg::OP_READ;
    localparam mmdf_pkg::t_op DO_WRITE = mmdf_pkg::OP_WRITE;
    localparam mmdf_pkg::t_op DO_FETCH = mmdf_pkg::OP_FETCH;
    localparam mmdf_pkg::t_op DO_LOAD  = mmdf_pkg::OP_LOAD;

    // index with no register behind it
    localparam logic [mmdf_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    typedef struct packed {
        mmdf_pkg::t_op op;
        logic [15:0]   addr;
        logic [7:0]    wd;
        logic [7:0]    ireg;
        logic [6:0]    rlo;
        logic          r7;
        logic [2:0]    row;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       shift_load;
        logic [7:0] shift_value;
    } t_reply;

    typedef struct packed {
        logic                            is_cfg;
        logic [mmdf_pkg::CFG_IDX_W-1:0]  idx;
        logic [mmdf_pkg::CFG_DATA_W-1:0] data;
        t_req                            req;
        logic                            checked;
        t_reply                          typed;
    } t_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [47:0]                     s_axis_tdata;
    logic [1:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [15:0]                     m_axis_tdata;
    logic [0:0]                      m_axis_tuser;
    logic                            i_cfg_we;
    logic [mmdf_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mmdf_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // local image of the store and of the map registers
    logic [7:0]     mem_img [0:mmdf_pkg::STORE_BYTES-1];
    mmdf_pkg::t_cfg cfg_shadow;
    t_reply         pending_replies [$];
    t_row           dir_rows [$];
    logic [15:0]    addr_hist [16];
    logic [3:0]     hist_ptr;
    int             mismatch_count = 0;
    bit             tx_no_idle;
    bit             rx_no_idle;
    bit             rx_hold;

    memory_map_display_fetch DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // address map model
    // ------------------------------------------------------------------
    function automatic logic [15:0] alt_window(input logic [15:0] a);
        logic [15:0] ofs;
        case (a[15:10])
            6'h08:   ofs = 16'h0400;
            6'h0a:   ofs = 16'h0400;
            6'h0c:   ofs = 16'h0c00;
            6'h0d:   ofs = 16'h0800;
            6'h0e:   ofs = 16'h0400;
            default: ofs = 16'h0000;
        endcase
        return a + ofs;
    endfunction

    function automatic logic [7:0] map_read(input logic [15:0] a);
        logic [15:0] m;
        if (cfg_shadow.mode == mmdf_pkg::MODE_ALT) begin
            m = alt_window(a);
            if (m >= mmdf_pkg::ALT_BLANK_LO && m <= mmdf_pkg::ALT_BLANK_HI)
                return 8'hff;
            return mem_img[m];
        end
        if (a[15] && cfg_shadow.mirror_upper_ram)
            return mem_img[{1'b0, a[14:0]}];
        if (a <= cfg_shadow.ram_top)
            return mem_img[a];
        return 8'hff;
    endfunction

    task automatic map_write(input logic [15:0] a, input logic [7:0] d);
        if (cfg_shadow.mode == mmdf_pkg::MODE_ALT) begin
            if (a >= mmdf_pkg::ALT_WR_FLOOR)
                mem_img[alt_window(a)] = d;
        end else if (!(cfg_shadow.protect_rom && a <= cfg_shadow.rom_top)) begin
            mem_img[a] = d;
        end
    endtask

    task automatic predict_access(input t_req r, output t_reply e);
        logic [7:0]  d;
        logic [15:0] pa;
        e = '0;
        case (r.op)
            mmdf_pkg::OP_READ:  e.read_data = map_read(r.addr);
            mmdf_pkg::OP_WRITE: map_write(r.addr, r.wd);
            mmdf_pkg::OP_LOAD:  mem_img[r.addr] = r.wd;
            mmdf_pkg::OP_FETCH: begin
                if (cfg_shadow.mode == mmdf_pkg::MODE_ALT) begin
                    e.read_data = mem_img[r.addr];
                end else begin
                    d = map_read({1'b0, r.addr[14:0]});
                    e.read_data = d;
                    // display fetch: CPU sees 0, pattern byte goes to the shifter outside fast mode
                    if (r.addr[15] && !d[6]) begin
                        e.read_data = '0;
                        if (!cfg_shadow.fast_mode) begin
                            if (r.ireg >= mmdf_pkg::HIRES_I_MIN && cfg_shadow.true_hires)
                                pa = {r.ireg, r.r7, r.rlo - 7'd1};
                            else
                                pa = {r.ireg, 8'h00} | {7'b0, d[5:0], r.row};
                            e.shift_value = d[7] ? ~mem_img[pa] : mem_img[pa];
                            e.shift_load  = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic report_bad(input string what, input logic [7:0] got,
                              input logic [7:0] want);
        if (mismatch_count < 40)
            $display("mismatch %s: got %02h, want %02h (t=%0t)", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic void add_access(input mmdf_pkg::t_op op, input logic [15:0] a,
                                       input logic [7:0] wd, input logic [7:0] ir,
                                       input logic [6:0] rl, input logic r7,
                                       input logic [2:0] rc, input logic chk,
                                       input logic [16:0] ans);
        t_row r;
        r = '0;
        r.req.op   = op;
        r.req.addr = a;
        r.req.wd   = wd;
        r.req.ireg = ir;
        r.req.rlo  = rl;
        r.req.r7   = r7;
        r.req.row  = rc;
        r.checked  = chk;
        r.typed    = ans;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [mmdf_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [mmdf_pkg::CFG_DATA_W-1:0] data);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [15:0] pick_addr();
        logic [15:0] a;
        int unsigned sel;
        a   = 16'($urandom);
        sel = $urandom_range(0, 9);
        case (sel)
            3, 4:    a = 16'($urandom_range(16'h1f00, 16'h3fff));
            5, 6, 7: a = addr_hist[4'($urandom_range(0, 15))];
            8:       a = 16'(cfg_shadow.rom_top + $urandom_range(0, 2) - 1);
            9:       a = 16'(cfg_shadow.ram_top + $urandom_range(0, 2) - 1);
            default: ;
        endcase
        return a;
    endfunction

    function automatic t_req random_req();
        t_req r;
        r.op   = mmdf_pkg::t_op'($urandom_range(0, 3));
        r.addr = pick_addr();
        r.wd   = 8'($urandom);
        r.ireg = 8'($urandom);
        r.rlo  = 7'($urandom);
        r.r7   = 1'($urandom);
        r.row  = 3'($urandom);
        return r;
    endfunction

    task automatic write_reg(input logic [mmdf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mmdf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            mmdf_pkg::CFG_MODE:       cfg_shadow.mode             = data[1:0];
            mmdf_pkg::CFG_PROTECT:    cfg_shadow.protect_rom      = data[0];
            mmdf_pkg::CFG_ROM_TOP:    cfg_shadow.rom_top          = data;
            mmdf_pkg::CFG_RAM_TOP:    cfg_shadow.ram_top          = data;
            mmdf_pkg::CFG_MIRROR:     cfg_shadow.mirror_upper_ram = data[0];
            mmdf_pkg::CFG_FAST:       cfg_shadow.fast_mode        = data[0];
            mmdf_pkg::CFG_TRUE_HIRES: cfg_shadow.true_hires       = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // stop offering, let every response come back, then let the pipe settle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // unused upper bits of the narrow registers carry noise
    task automatic load_setting(input mmdf_pkg::t_cfg c);
        logic [15:0] v;
        settle();
        v = 16'($urandom); v[1:0] = c.mode;             write_reg(mmdf_pkg::CFG_MODE, v);
        v = 16'($urandom); v[0]   = c.protect_rom;      write_reg(mmdf_pkg::CFG_PROTECT, v);
        write_reg(mmdf_pkg::CFG_ROM_TOP, c.rom_top);
        write_reg(mmdf_pkg::CFG_RAM_TOP, c.ram_top);
        v = 16'($urandom); v[0]   = c.mirror_upper_ram; write_reg(mmdf_pkg::CFG_MIRROR, v);
        v = 16'($urandom); v[0]   = c.fast_mode;        write_reg(mmdf_pkg::CFG_FAST, v);
        v = 16'($urandom); v[0]   = c.true_hires;       write_reg(mmdf_pkg::CFG_TRUE_HIRES, v);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_req(input t_req r, input logic chk, input t_reply typed);
        int     gap;
        t_reply e;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {5'b0, r.row, r.r7, r.rlo, r.ireg, r.wd, r.addr};
        s_axis_tuser  <= r.op;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_access(r, e);
        pending_replies.push_back(chk ? typed : e);
        if (r.op == mmdf_pkg::OP_WRITE || r.op == mmdf_pkg::OP_LOAD) begin
            addr_hist[hist_ptr] = r.addr;
            hist_ptr = hist_ptr + 1'b1;
        end
    endtask

    // character byte, both candidate pattern bytes, then a fetch of the character, mostly a display fetch
    task automatic run_display_seq();
        t_req        c;
        t_req        p;
        t_reply      none;
        logic [14:0] spot;
        logic [7:0]  ch;
        none = '0;
        spot = 15'($urandom);
        ch   = 8'($urandom);
        if ($urandom_range(0, 4) != 0)
            ch[6] = 1'b0;
        c      = random_req();
        c.op   = mmdf_pkg::OP_LOAD;
        c.addr = {1'b0, spot};
        c.wd   = ch;
        send_req(c, PRED, none);
        p      = c;
        p.addr = {c.ireg, 8'h00} | {7'b0, ch[5:0], c.row};
        p.wd   = 8'($urandom);
        send_req(p, PRED, none);
        p.addr = {c.ireg, c.r7, c.rlo - 7'd1};
        p.wd   = 8'($urandom);
        send_req(p, PRED, none);
        p.op   = mmdf_pkg::OP_FETCH;
        p.addr = {($urandom_range(0, 9) != 0), spot};
        send_req(p, PRED, none);
    endtask

    // ------------------------------------------------------------------
    // response side
    // ------------------------------------------------------------------
    initial begin
        int     gap;
        t_reply e;
        bit     held;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (rx_hold && !held) begin
                gap  = RX_HOLD_CYCLES;
                held = 1'b1;
            end else begin
                gap = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (pending_replies.size() == 0) begin
                report_bad("response with no request pending", m_axis_tdata[7:0], 8'h00);
            end else begin
                e = pending_replies.pop_front();
                if (m_axis_tdata[7:0] !== e.read_data)
                    report_bad("read_data", m_axis_tdata[7:0], e.read_data);
                if (m_axis_tuser[0] !== e.shift_load)
                    report_bad("shift_load", {7'b0, m_axis_tuser[0]}, {7'b0, e.shift_load});
                if (m_axis_tdata[15:8] !== e.shift_value)
                    report_bad("shift_value", m_axis_tdata[15:8], e.shift_value);
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    initial begin
        mmdf_pkg::t_cfg setting;
        int             n;
        bit             paused;
        t_reply         none;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = mmdf_pkg::OP_READ;
        i_cfg_we       = 1'b0;
        i_cfg_index    = mmdf_pkg::CFG_MODE;
        i_cfg_data     = '0;
        cfg_shadow     = mmdf_pkg::CFG_RESET;
        tx_no_idle     = 1'b0;
        rx_no_idle     = 1'b0;
        rx_hold        = 1'b0;
        hist_ptr       = '0;
        paused         = 1'b0;
        none           = '0;
        for (int k = 0; k < mmdf_pkg::STORE_BYTES; k++)
            mem_img[k] = 8'h00;
        for (int k = 0; k < 16; k++)
            addr_hist[k] = 16'h0000;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; reset map: newer model, ROM to 8191, RAM to 32767
        add_cfg(CFG_NO_REG, 16'hffff);
        add_access(DO_READ,  16'h0000, 8'h00, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_READ,  16'hffff, 8'h00, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'hff, 1'b0, 8'h00});
        add_access(DO_WRITE, 16'h0000, 8'hff, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_READ,  16'h0000, 8'h00, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_LOAD,  16'h0000, 8'h3f, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_READ,  16'h0000, 8'h00, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h3f, 1'b0, 8'h00});
        add_access(DO_WRITE, 16'h2000, 8'ha5, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_READ,  16'h2000, 8'h00, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'ha5, 1'b0, 8'h00});
        // character 0x3f, row 7, I 0x20 -> pattern at 0x21ff
        add_access(DO_LOAD,  16'h21ff, 8'h5a, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_FETCH, 16'h8000, 8'h00, 8'h20, 7'h00, 1'b0, 3'd7, TYPED, {8'h00, 1'b1, 8'h5a});
        // bit 7 set: same pattern, inverted
        add_access(DO_LOAD,  16'h0001, 8'hbf, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_FETCH, 16'h8001, 8'h00, 8'h20, 7'h00, 1'b0, 3'd7, TYPED, {8'h00, 1'b1, 8'ha5});
        // bit 6 set: plain fetch
        add_access(DO_LOAD,  16'h0002, 8'h40, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_FETCH, 16'h8002, 8'h00, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h40, 1'b0, 8'h00});
        add_access(DO_FETCH, 16'hffff, 8'hff, 8'hff, 7'h7f, 1'b1, 3'd7, PRED,  17'h0);
        add_cfg(mmdf_pkg::CFG_TRUE_HIRES, 16'h0001);
        // R low 0 wraps to 127
        add_access(DO_LOAD,  16'h207f, 8'h33, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_FETCH, 16'h8000, 8'h00, 8'h20, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b1, 8'h33});
        add_access(DO_FETCH, 16'h8001, 8'h00, 8'hff, 7'h7f, 1'b1, 3'd7, PRED,  17'h0);
        add_cfg(mmdf_pkg::CFG_FAST, 16'h0001);
        add_access(DO_FETCH, 16'h8000, 8'h00, 8'h20, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_cfg(mmdf_pkg::CFG_FAST, 16'h0000);
        add_cfg(mmdf_pkg::CFG_MODE, {14'b0, mmdf_pkg::MODE_ALT});
        add_access(DO_WRITE, 16'h1fff, 8'h11, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_WRITE, 16'h2000, 8'h77, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_READ,  16'h2000, 8'h00, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h77, 1'b0, 8'h00});
        add_access(DO_READ,  16'h2800, 8'h00, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'hff, 1'b0, 8'h00});
        // fetch in the alternate machine ignores the window remap
        add_access(DO_FETCH, 16'h2000, 8'h00, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'ha5, 1'b0, 8'h00});
        add_cfg(mmdf_pkg::CFG_MODE, 16'h0003);
        add_cfg(mmdf_pkg::CFG_PROTECT, 16'h0000);
        add_cfg(mmdf_pkg::CFG_RAM_TOP, 16'hffff);
        add_cfg(mmdf_pkg::CFG_MIRROR, 16'h0001);
        add_access(DO_WRITE, 16'h0000, 8'h99, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h00, 1'b0, 8'h00});
        add_access(DO_READ,  16'h8000, 8'h00, 8'h00, 7'h00, 1'b0, 3'd0, TYPED, {8'h99, 1'b0, 8'h00});

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                settle();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
                i_cfg_we <= 1'b0;
            end else begin
                send_req(dir_rows[k].req, dir_rows[k].checked, dir_rows[k].typed);
            end
        end

        // random phases
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: setting = mmdf_pkg::CFG_RESET;
                1: setting = '{mode: 2'd0, protect_rom: 1'b1, rom_top: 16'h0000,
                               ram_top: 16'hffff, mirror_upper_ram: 1'b0,
                               fast_mode: 1'b0, true_hires: 1'b1};
                2: setting = '{mode: 2'd1, protect_rom: 1'b0, rom_top: 16'hffff,
                               ram_top: 16'h0000, mirror_upper_ram: 1'b1,
                               fast_mode: 1'b0, true_hires: 1'b1};
                3: setting = '{mode: mmdf_pkg::MODE_ALT, protect_rom: 1'b1,
                               rom_top: 16'd8191, ram_top: 16'd32767,
                               mirror_upper_ram: 1'b0, fast_mode: 1'b0,
                               true_hires: 1'b1};
                4: setting = '{mode: 2'd3, protect_rom: 1'b1, rom_top: 16'hffff,
                               ram_top: 16'hffff, mirror_upper_ram: 1'b1,
                               fast_mode: 1'b0, true_hires: 1'b0};
                5: setting = '{mode: 2'd1, protect_rom: 1'b1, rom_top: 16'h1fff,
                               ram_top: 16'h3fff, mirror_upper_ram: 1'b0,
                               fast_mode: 1'b1, true_hires: 1'b0};
                default: begin
                    setting.mode             = 2'($urandom_range(0, 3));
                    setting.protect_rom      = 1'($urandom);
                    setting.rom_top          = 16'($urandom);
                    setting.ram_top          = 16'($urandom);
                    setting.mirror_upper_ram = 1'($urandom);
                    setting.fast_mode        = 1'($urandom);
                    setting.true_hires       = 1'($urandom);
                end
            endcase
            load_setting(setting);
            tx_no_idle = (p == 1 || p == 5);
            rx_no_idle = (p == 1 || p == 6);
            if (p == 2)
                rx_hold = 1'b1;   // output side stalls while requests keep coming
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (p == 4 && n >= 60 && !paused) begin
                    paused = 1'b1;
                    s_axis_tvalid <= 1'b0;
                    do @(posedge i_clk); while (pending_replies.size() != 0);
                end
                if ($urandom_range(0, 99) < 45) begin
                    run_display_seq();
                    n += 4;
                end else begin
                    send_req(random_req(), PRED, none);
                    n++;
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
